/* hdl/adsr_echo_envelope_unit_defines.svh */
// Assertion macros for the envelope unit checker.
// Expect clk_i and rst_ni in the scope of use.
`ifndef ADSR_ECHO_ENVELOPE_UNIT_DEFINES_SVH
`define ADSR_ECHO_ENVELOPE_UNIT_DEFINES_SVH

// same-cycle implication
`define AEE_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("aee: property violated");

// next-cycle implication
`define AEE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("aee: property violated");

`endif

/* hdl/aee_pkg.sv */
// Shared types and constants of the envelope unit.
// No dependencies.
package aee_pkg;

  localparam int unsigned ADDR_W = 5;

  localparam logic [7:0] ST_START  = 8'h80;
  localparam logic [7:0] ST_STOP   = 8'h40;
  localparam logic [7:0] ST_LOOP   = 8'h10;
  localparam logic [7:0] ST_ECHO   = 8'h04;
  localparam logic [7:0] ST_LIVE   = 8'hC7;
  localparam logic [7:0] ST_STAGE  = 8'h03;
  localparam logic [7:0] LEVEL_MAX = 8'hFF;

  localparam logic [1:0] STAGE_ATTACK  = 2'd3;
  localparam logic [1:0] STAGE_DECAY   = 2'd2;

  typedef enum logic [2:0] {
    REG_ATTACK_STEP   = 3'd0,
    REG_DECAY_RATE    = 3'd1,
    REG_SUSTAIN_LEVEL = 3'd2,
    REG_RELEASE_RATE  = 3'd3,
    REG_ECHO_LEVEL    = 3'd4,
    REG_MASTER_VOLUME = 3'd5,
    REG_LEFT_VOLUME   = 3'd6,
    REG_RIGHT_VOLUME  = 3'd7
  } aee_reg_e;

  typedef enum logic [2:0] {
    PH_OFF     = 3'd0,
    PH_ATTACK  = 3'd1,
    PH_DECAY   = 3'd2,
    PH_SUSTAIN = 3'd3,
    PH_RELEASE = 3'd4,
    PH_ECHO    = 3'd5
  } aee_phase_e;

  typedef struct packed {
    logic [7:0] attack_step;
    logic [7:0] decay_rate;
    logic [7:0] sustain_level;
    logic [7:0] release_rate;
    logic [7:0] echo_level;
    logic [3:0] master_volume;
    logic [7:0] left_volume;
    logic [7:0] right_volume;
  } aee_cfg_t;

  localparam aee_cfg_t CFG_RESET = '{
    attack_step:   8'd255,
    decay_rate:    8'd0,
    sustain_level: 8'd255,
    release_rate:  8'd0,
    echo_level:    8'd0,
    master_volume: 4'd15,
    left_volume:   8'd128,
    right_volume:  8'd128
  };

  typedef struct packed {
    logic start_request;
    logic stop_request;
    logic loop_enabled;
  } aee_in_t;

  typedef struct packed {
    logic       active;
    logic [7:0] envelope_out;
    logic [7:0] left_level;
    logic [7:0] right_level;
    logic [2:0] phase;
    logic       looping;
  } aee_out_t;

  typedef struct packed {
    logic load;
    logic tick;
    logic gain;
    logic left;
    logic emit;
  } aee_cmd_t;

endpackage

/* hdl/aee_if.sv */
// Valid/ready channels of the envelope unit: frame requests in, levels out.
// No dependencies.
interface aee_in_if;
  logic valid;
  logic ready;
  logic start_request;
  logic stop_request;
  logic loop_enabled;

  modport source (output valid, output start_request, output stop_request,
                  output loop_enabled, input ready);
  modport sink   (input valid, input start_request, input stop_request,
                  input loop_enabled, output ready);
endinterface

interface aee_out_if;
  logic       valid;
  logic       ready;
  logic       active;
  logic [7:0] envelope_out;
  logic [7:0] left_level;
  logic [7:0] right_level;
  logic [2:0] phase;
  logic       looping;

  modport source (output valid, output active, output envelope_out, output left_level,
                  output right_level, output phase, output looping, input ready);
  modport sink   (input valid, input active, input envelope_out, input left_level,
                  input right_level, input phase, input looping, output ready);
endinterface

/* hdl/aee_cfg_regs.sv */
// APB-style configuration register file of the envelope unit.
// Depends on aee_pkg.
module aee_cfg_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel_i,
  input  logic                       penable_i,
  input  logic                       pwrite_i,
  input  logic [aee_pkg::ADDR_W-1:0] paddr_i,
  input  logic [31:0]                pwdata_i,
  output logic [31:0]                prdata_o,
  output aee_pkg::aee_cfg_t          cfg_o
);
  import aee_pkg::*;

  aee_cfg_t cfg_q;
  aee_reg_e reg_idx;
  logic     wr_en;

  assign reg_idx = aee_reg_e'(paddr_i[ADDR_W-1:2]);
  assign wr_en   = psel_i && penable_i && pwrite_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_ATTACK_STEP:   cfg_q.attack_step   <= pwdata_i[7:0];
        REG_DECAY_RATE:    cfg_q.decay_rate    <= pwdata_i[7:0];
        REG_SUSTAIN_LEVEL: cfg_q.sustain_level <= pwdata_i[7:0];
        REG_RELEASE_RATE:  cfg_q.release_rate  <= pwdata_i[7:0];
        REG_ECHO_LEVEL:    cfg_q.echo_level    <= pwdata_i[7:0];
        REG_MASTER_VOLUME: cfg_q.master_volume <= pwdata_i[3:0];
        REG_LEFT_VOLUME:   cfg_q.left_volume   <= pwdata_i[7:0];
        REG_RIGHT_VOLUME:  cfg_q.right_volume  <= pwdata_i[7:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ATTACK_STEP:   prdata_o = {24'd0, cfg_q.attack_step};
      REG_DECAY_RATE:    prdata_o = {24'd0, cfg_q.decay_rate};
      REG_SUSTAIN_LEVEL: prdata_o = {24'd0, cfg_q.sustain_level};
      REG_RELEASE_RATE:  prdata_o = {24'd0, cfg_q.release_rate};
      REG_ECHO_LEVEL:    prdata_o = {24'd0, cfg_q.echo_level};
      REG_MASTER_VOLUME: prdata_o = {28'd0, cfg_q.master_volume};
      REG_LEFT_VOLUME:   prdata_o = {24'd0, cfg_q.left_volume};
      REG_RIGHT_VOLUME:  prdata_o = {24'd0, cfg_q.right_volume};
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

/* hdl/aee_ctrl.sv */
// Sequencer of the envelope unit: handshakes and datapath step commands.
// Depends on aee_pkg.
module aee_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output aee_pkg::aee_cmd_t cmd_o
);
  import aee_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TICK,
    S_GAIN,
    S_LEFT,
    S_RIGHT
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;
  logic   emit;
  logic   load;

  assign out_free   = !out_valid_q || out_ready_i;
  assign emit       = (state_q == S_RIGHT) && out_free;
  assign in_ready_o = (state_q == S_IDLE) || emit;
  assign load       = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (load) state_q <= S_TICK;
        end
        S_TICK:  state_q <= S_GAIN;
        S_GAIN:  state_q <= S_LEFT;
        S_LEFT:  state_q <= S_RIGHT;
        S_RIGHT: begin
          if (emit) state_q <= load ? S_TICK : S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign cmd_o.load  = load;
  assign cmd_o.tick  = (state_q == S_TICK);
  assign cmd_o.gain  = (state_q == S_GAIN);
  assign cmd_o.left  = (state_q == S_LEFT);
  assign cmd_o.emit  = emit;

endmodule

/* hdl/aee_datapath.sv */
// Envelope datapath: voice state, one shared 8x8 multiplier, result register.
// Depends on aee_pkg.
module aee_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  aee_pkg::aee_cfg_t cfg_i,
  input  aee_pkg::aee_cmd_t cmd_i,
  input  aee_pkg::aee_in_t  req_i,
  output aee_pkg::aee_out_t res_o
);
  import aee_pkg::*;

  logic [7:0] status_q, status_d;
  logic [7:0] env_q, env_d;
  logic [7:0] echo_q, echo_d;
  logic [7:0] gain_q;
  logic [7:0] left_q;
  aee_out_t   res_q;
  aee_out_t   res_d;

  logic [7:0]  mul_a, mul_b;
  logic [15:0] mul_p;
  logic [7:0]  scaled;
  logic [8:0]  atk_sum;
  logic        live;
  logic [7:0]  echo_or_off;

  assign live        = (status_q & ST_LIVE) != 8'd0;
  assign atk_sum     = {1'b0, env_q} + {1'b0, cfg_i.attack_step};
  assign echo_or_off = (echo_q == 8'd0) ? 8'd0 : (status_q | ST_ECHO);

  always_comb begin
    mul_a = env_q;
    mul_b = cfg_i.decay_rate;
    if (cmd_i.emit) begin
      mul_a = cfg_i.right_volume;
      mul_b = gain_q;
    end else if (cmd_i.left) begin
      mul_a = cfg_i.left_volume;
      mul_b = gain_q;
    end else if (cmd_i.gain) begin
      mul_b = {3'd0, {1'b0, cfg_i.master_volume} + 5'd1};
    end else if ((status_q & ST_STOP) != 8'd0) begin
      mul_b = cfg_i.release_rate;
    end
  end

  assign mul_p  = 16'(mul_a) * 16'(mul_b);
  assign scaled = mul_p[15:8];

  always_comb begin
    status_d = status_q;
    env_d    = env_q;
    echo_d   = echo_q;
    if (cmd_i.load) begin
      if (req_i.start_request) begin
        status_d = ST_START | (req_i.stop_request ? ST_STOP : 8'd0)
                 | (req_i.loop_enabled ? ST_LOOP : 8'd0);
      end else if (req_i.stop_request && live) begin
        status_d = status_q | ST_STOP;
      end
    end else if (cmd_i.tick && live) begin
      priority if ((status_q & ST_START) != 8'd0) begin
        if ((status_q & ST_STOP) != 8'd0) begin
          status_d = 8'd0;
        end else begin
          status_d = {6'd0, STAGE_ATTACK} | (status_q & ST_LOOP);
          env_d    = cfg_i.attack_step;
          echo_d   = cfg_i.echo_level;
        end
      end else if ((status_q & ST_ECHO) != 8'd0) begin
        if (echo_q <= 8'd1) begin
          echo_d   = 8'd0;
          status_d = 8'd0;
        end else begin
          echo_d = echo_q - 8'd1;
        end
      end else if ((status_q & ST_STOP) != 8'd0) begin
        env_d = scaled;
        if (scaled <= echo_q) status_d = echo_or_off;
      end else begin
        unique case (status_q[1:0])
          STAGE_ATTACK: begin
            if (atk_sum[8]) begin
              env_d    = LEVEL_MAX;
              status_d = status_q - 8'd1;
            end else begin
              env_d = atk_sum[7:0];
            end
          end
          STAGE_DECAY: begin
            env_d = scaled;
            if (scaled <= cfg_i.sustain_level) begin
              if (cfg_i.sustain_level == 8'd0) begin
                status_d = echo_or_off;
              end else begin
                env_d    = cfg_i.sustain_level;
                status_d = status_q - 8'd1;
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    res_d              = '0;
    res_d.active       = live;
    res_d.envelope_out = env_q;
    if (live) begin
      res_d.left_level  = left_q;
      res_d.right_level = scaled;
      res_d.looping     = (status_q & ST_LOOP) != 8'd0;
      priority if ((status_q & ST_ECHO) != 8'd0) begin
        res_d.phase = PH_ECHO;
      end else if ((status_q & ST_STOP) != 8'd0) begin
        res_d.phase = PH_RELEASE;
      end else if ((status_q & ST_STAGE) == {6'd0, STAGE_ATTACK}) begin
        res_d.phase = PH_ATTACK;
      end else if ((status_q & ST_STAGE) == {6'd0, STAGE_DECAY}) begin
        res_d.phase = PH_DECAY;
      end else begin
        res_d.phase = PH_SUSTAIN;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q <= 8'd0;
      env_q    <= 8'd0;
      echo_q   <= 8'd0;
    end else begin
      status_q <= status_d;
      env_q    <= env_d;
      echo_q   <= echo_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.gain) gain_q <= mul_p[11:4];
    if (cmd_i.left) left_q <= scaled;
    if (cmd_i.emit) res_q  <= res_d;
  end

  assign res_o = res_q;

endmodule

/* hdl/adsr_echo_envelope_unit.sv */
// Top level of the one-voice ADSR envelope unit with echo tail.
// Each frame runs the tick, master gain, left and right steps in turn on the single
// 8x8 multiplier they share; a new frame is taken only when the last result is
// emitted, which waits until the output channel is free. Reset clears the voice
// to off and loads register defaults at once; no clearing pass.
module adsr_echo_envelope_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  aee_in_if.sink                     in_i,
  aee_out_if.source                  out_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [aee_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import aee_pkg::*;

  aee_cfg_t cfg;
  aee_cmd_t cmd;
  aee_in_t  req;
  aee_out_t res;
  logic     in_ready;
  logic     out_valid;

  assign pready = 1'b1;

  aee_cfg_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .cfg_o     (cfg)
  );

  aee_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd)
  );

  assign req.start_request = in_i.start_request;
  assign req.stop_request  = in_i.stop_request;
  assign req.loop_enabled  = in_i.loop_enabled;

  aee_datapath u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .cmd_i  (cmd),
    .req_i  (req),
    .res_o  (res)
  );

  assign in_i.ready         = in_ready;
  assign out_o.valid        = out_valid;
  assign out_o.active       = res.active;
  assign out_o.envelope_out = res.envelope_out;
  assign out_o.left_level   = res.left_level;
  assign out_o.right_level  = res.right_level;
  assign out_o.phase        = res.phase;
  assign out_o.looping      = res.looping;

endmodule

/* hdl/aee_checker.sv */
// Port-level checks of the envelope unit, bound to the top level.
// Depends on aee_pkg and adsr_echo_envelope_unit_defines.svh.
`include "adsr_echo_envelope_unit_defines.svh"

module aee_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       out_active_i,
  input logic [7:0] out_env_i,
  input logic [7:0] out_left_i,
  input logic [7:0] out_right_i,
  input logic [2:0] out_phase_i,
  input logic       out_looping_i
);
  import aee_pkg::*;

  logic        silent_ok;
  logic        gain_ok;
  logic [28:0] out_bus;

  assign silent_ok = (out_phase_i == PH_OFF) && (out_left_i == 8'd0) &&
                     (out_right_i == 8'd0) && !out_looping_i;
  assign gain_ok   = (out_left_i <= out_env_i) && (out_right_i <= out_env_i);
  assign out_bus   = {out_active_i, out_env_i, out_left_i, out_right_i, out_phase_i,
                      out_looping_i};

  `AEE_ASSERT_IMP(a_silent_zero, out_valid_i && !out_active_i, silent_ok)
  `AEE_ASSERT_IMP(a_gain_bound, out_valid_i, gain_ok)
  `AEE_ASSERT_NEXT(a_one_frame, in_valid_i && in_ready_i, !in_ready_i)
  `AEE_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_bus))

endmodule

bind adsr_echo_envelope_unit aee_checker u_aee_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_active_i  (out_o.active),
  .out_env_i     (out_o.envelope_out),
  .out_left_i    (out_o.left_level),
  .out_right_i   (out_o.right_level),
  .out_phase_i   (out_o.phase),
  .out_looping_i (out_o.looping)
);
